// ----- hw/rtl/assert_macros.svh -----
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, dropped while reset is low
`define PTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define PTP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ptp_pkg.sv -----
package ptp_pkg;

    // stream and config port widths
    localparam int IN_W   = 160;
    localparam int OUT_W  = 48;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef logic [3:0] t_op;
    typedef logic [2:0] t_cond;
    typedef logic [1:0] t_ksel;
    typedef logic [4:0] t_pc;
    typedef logic [1:0] t_lay;
    typedef logic [CFG_AW-1:0] t_reg;

    // micro operations
    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_EMIT  = 4'd1;
    localparam t_op OP_NEXT  = 4'd2;
    localparam t_op OP_SUMX  = 4'd3;
    localparam t_op OP_ABS_A = 4'd4;
    localparam t_op OP_ABS_P = 4'd5;
    localparam t_op OP_MULK  = 4'd6;
    localparam t_op OP_QUO   = 4'd7;
    localparam t_op OP_MULF  = 4'd8;
    localparam t_op OP_SUMY1 = 4'd9;
    localparam t_op OP_SUMY2 = 4'd10;
    localparam t_op OP_MULM  = 4'd11;
    localparam t_op OP_IV    = 4'd12;
    localparam t_op OP_MULV  = 4'd13;
    localparam t_op OP_CLAMP = 4'd14;

    // jump conditions
    localparam t_cond C_NONE   = 3'd0;
    localparam t_cond C_ALWAYS = 3'd1;
    localparam t_cond C_NOIN   = 3'd2;
    localparam t_cond C_BANK0  = 3'd3;
    localparam t_cond C_MORE   = 3'd4;
    localparam t_cond C_ISNEAR = 3'd5;

    // constant divisor select
    localparam t_ksel K100  = 2'd0;
    localparam t_ksel K1000 = 2'd1;
    localparam t_ksel K80   = 2'd2;
    localparam t_ksel KW    = 2'd3;

    // layers
    localparam t_lay LAY_FIX  = 2'd0;
    localparam t_lay LAY_MID  = 2'd1;
    localparam t_lay LAY_NEAR = 2'd2;

    // register indexes
    localparam t_reg REG_FIX_BANK  = 3'd0;
    localparam t_reg REG_MID_BANK  = 3'd1;
    localparam t_reg REG_MID_BASE  = 3'd2;
    localparam t_reg REG_MID_VERT  = 3'd3;
    localparam t_reg REG_NEAR_BANK = 3'd4;
    localparam t_reg REG_NEAR_BASE = 3'd5;
    localparam t_reg REG_NEAR_VERT = 3'd6;

    // reciprocal multipliers and shifts, exact for unsigned 32-bit dividends
    localparam logic [31:0] MAG100  = 32'h51EB851F;
    localparam logic [31:0] MAG1000 = 32'h10624DD3;
    localparam logic [31:0] MAG5    = 32'hCCCCCCCD;
    localparam int SH100  = 37;
    localparam int SH1000 = 38;
    localparam int SH80   = 34;
    localparam int SHW    = 24;

    localparam logic signed [32:0] Y_MAGIC  = -33'sh51EB851F;
    localparam logic signed [32:0] FACT_MID = 33'sd250;
    localparam logic signed [32:0] FACT_NEAR = 33'sd500;
    localparam logic signed [32:0] COARSE_MUL = 33'sd100;
    localparam logic [10:0] TILE_W = 11'd80;
    localparam logic signed [31:0] YOFF_MIN = -32'sd28;

    typedef struct packed {
        t_op   op;
        t_ksel k;
        t_cond cond;
        t_pc   tgt;
    } t_uword;

    function automatic t_uword uw(input t_op op, input t_ksel k, input t_cond cond,
                                  input t_pc tgt);
        t_uword w;
        w.op   = op;
        w.k    = k;
        w.cond = cond;
        w.tgt  = tgt;
        return w;
    endfunction

    // control program
    function automatic t_uword uprog(input t_pc pc);
        t_uword w;
        case (pc)
            5'd0:  w = uw(OP_NOP,   K100,  C_NOIN,   5'd0);
            5'd1:  w = uw(OP_NOP,   K100,  C_BANK0,  5'd3);
            5'd2:  w = uw(OP_EMIT,  K100,  C_MORE,   5'd2);
            5'd3:  w = uw(OP_NEXT,  K100,  C_NONE,   5'd0);
            5'd4:  w = uw(OP_NOP,   K100,  C_BANK0,  5'd29);
            5'd5:  w = uw(OP_SUMX,  K100,  C_NONE,   5'd0);
            5'd6:  w = uw(OP_ABS_A, K100,  C_NONE,   5'd0);
            5'd7:  w = uw(OP_MULK,  K100,  C_NONE,   5'd0);
            5'd8:  w = uw(OP_QUO,   K100,  C_NONE,   5'd0);
            5'd9:  w = uw(OP_MULF,  K100,  C_NONE,   5'd0);
            5'd10: w = uw(OP_ABS_P, K100,  C_NONE,   5'd0);
            5'd11: w = uw(OP_MULK,  K1000, C_NONE,   5'd0);
            5'd12: w = uw(OP_QUO,   K1000, C_NONE,   5'd0);
            5'd13: w = uw(OP_ABS_A, K100,  C_NONE,   5'd0);
            5'd14: w = uw(OP_MULK,  K80,   C_NONE,   5'd0);
            5'd15: w = uw(OP_QUO,   K80,   C_NONE,   5'd0);
            5'd16: w = uw(OP_ABS_A, K100,  C_NONE,   5'd0);
            5'd17: w = uw(OP_MULK,  KW,    C_NONE,   5'd0);
            5'd18: w = uw(OP_QUO,   KW,    C_NONE,   5'd0);
            5'd19: w = uw(OP_SUMY1, K100,  C_NONE,   5'd0);
            5'd20: w = uw(OP_SUMY2, K100,  C_NONE,   5'd0);
            5'd21: w = uw(OP_MULM,  K100,  C_NONE,   5'd0);
            5'd22: w = uw(OP_IV,    K100,  C_NONE,   5'd0);
            5'd23: w = uw(OP_MULV,  K100,  C_NONE,   5'd0);
            5'd24: w = uw(OP_ABS_P, K100,  C_NONE,   5'd0);
            5'd25: w = uw(OP_MULK,  K1000, C_NONE,   5'd0);
            5'd26: w = uw(OP_QUO,   K1000, C_NONE,   5'd0);
            5'd27: w = uw(OP_CLAMP, K100,  C_NONE,   5'd0);
            5'd28: w = uw(OP_EMIT,  K100,  C_MORE,   5'd28);
            5'd29: w = uw(OP_NOP,   K100,  C_ISNEAR, 5'd0);
            5'd30: w = uw(OP_NEXT,  K100,  C_ALWAYS, 5'd4);
            default: w = uw(OP_NOP, K100,  C_ALWAYS, 5'd0);
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/parallax_tile_placer.sv -----
// parallax tile placer
// slave stream takes one camera position per video frame; tdata holds
// scroll_x_main, scroll_x_extra, pos_y_fine, pos_y_coarse, pos_y_extra.
// master stream gives the tile placements of the fixed layer, then the
// middle strip, then the near strip; tlast marks the final placement.
// a layer whose bank register is zero gives nothing; with all banks zero
// a request gives no placement at all.
// the config port writes one register per cycle; the user must write only while
// the block is idle, as the block does not enforce it. a request is taken only when
// the sequencer sits in its idle step. with the fixed layer on, the emit step after
// the bank test loads the first placement. with all layers on, a request runs the
// fixed bank test and FIXED_TILES emits, each strip's 24 program steps through the
// one shared 33x33 multiplier plus STRIP_TILES emits, and glue and idle steps.
// during emit steps one placement leaves per cycle while the receiver takes them;
// when it stalls, the output register holds its placement and the program waits
// on its emit step.
// synchronous reset zeroes control and config registers; the program goes idle.
module parallax_tile_placer #(
    parameter int STRIP_WRAP  = 8,
    parameter int STRIP_TILES = 9,
    parameter int FIXED_TILES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // scroll_x_main[31:0], scroll_x_extra[63:32], pos_y_fine[95:64],
    // pos_y_coarse[121:96], pos_y_extra[153:122], zero pad
    input  logic [ptp_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // tile_bank[15:0], tile_frame[19:16], screen_x[30:20], screen_y[47:31]
    output logic [ptp_pkg::OUT_W-1:0]   o_m_axis_tdata,
    output logic                        o_m_axis_tlast,
    input  logic                        i_cfg_we,
    input  logic [ptp_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [ptp_pkg::CFG_DW-1:0]  i_cfg_wdata
);
    import ptp_pkg::*;

    localparam int TILE_MAX = (FIXED_TILES > STRIP_TILES) ? FIXED_TILES : STRIP_TILES;
    localparam int TW  = (TILE_MAX > 1) ? $clog2(TILE_MAX) : 1;
    localparam int FRW = $clog2(STRIP_WRAP) + 1;
    localparam logic [31:0] WRAP_MAG = 32'((1 << SHW) / STRIP_WRAP + 1);
    localparam logic [6:0] WRAP_D = 7'(STRIP_WRAP);
    localparam logic signed [FRW:0] WRAP_EQ = (FRW+1)'(STRIP_WRAP);
    localparam logic signed [FRW-1:0] FRM_NEGMAX = FRW'(1 - STRIP_WRAP);
    localparam logic [TW-1:0] FIX_END = TW'(FIXED_TILES - 1);
    localparam logic [TW-1:0] STRIP_END = TW'(STRIP_TILES - 1);

    // configuration
    logic [15:0] r_fix_bank, r_mid_bank, r_mid_base, r_near_bank, r_near_base;
    logic [9:0]  r_mid_vert, r_near_vert;

    // control
    t_pc         r_pc, n_pc;
    t_lay        r_lay, n_lay;
    logic [TW-1:0] r_tile, n_tile;
    logic        r_ovalid, n_ovalid;

    // datapath
    logic [153:0]         r_in, n_in;
    logic signed [31:0]   r_a, n_a;
    logic [31:0]          r_mag, n_mag;
    logic                 r_s, n_s;
    logic signed [65:0]   r_p, n_p;
    logic [10:0]          r_x, n_x;
    logic signed [FRW-1:0] r_frm, n_frm;
    logic signed [15:0]   r_v, n_v;
    logic signed [5:0]    r_yoff, n_yoff;

    // output register
    logic [15:0] r_obank, n_obank;
    logic [3:0]  r_ofrm, n_ofrm;
    logic [10:0] r_ox, n_ox;
    logic [16:0] r_oy, n_oy;
    logic        r_olast, n_olast;

    t_uword uword;
    logic   in_acc, slot_free, tile_end, later_off, jump;
    logic [15:0] bank_cur, base_cur;
    logic [9:0]  vert_cur;
    logic [TW-1:0] tile_last;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [31:0] kmag, q, qs, abs_src;
    logic [6:0]  kdiv, rem;
    logic [13:0] qd;
    logic signed [31:0] iv;
    logic signed [FRW:0] frm_inc;

    assign uword           = uprog(r_pc);
    assign o_s_axis_tready = (r_pc == 5'd0);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free       = !r_ovalid || i_m_axis_tready;
    assign tile_end        = (r_tile == tile_last);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_oy, r_ox, r_ofrm, r_obank};
    assign o_m_axis_tlast  = r_olast;

    always_comb begin
        case (r_lay)
            LAY_FIX: begin
                bank_cur  = r_fix_bank;
                tile_last = FIX_END;
                later_off = (r_mid_bank == 16'd0) && (r_near_bank == 16'd0);
            end
            LAY_MID: begin
                bank_cur  = r_mid_bank;
                tile_last = STRIP_END;
                later_off = (r_near_bank == 16'd0);
            end
            default: begin
                bank_cur  = r_near_bank;
                tile_last = STRIP_END;
                later_off = 1'b1;
            end
        endcase
        base_cur = (r_lay == LAY_NEAR) ? r_near_base : r_mid_base;
        vert_cur = (r_lay == LAY_NEAR) ? r_near_vert : r_mid_vert;
    end

    always_comb begin
        case (uword.cond)
            C_NONE:   jump = 1'b0;
            C_ALWAYS: jump = 1'b1;
            C_NOIN:   jump = !in_acc;
            C_BANK0:  jump = (bank_cur == 16'd0);
            C_MORE:   jump = !(slot_free && tile_end);
            C_ISNEAR: jump = (r_lay == LAY_NEAR);
            default:  jump = 1'b0;
        endcase
    end

    // constant divisor tables
    always_comb begin
        case (uword.k)
            K100:    begin kmag = MAG100;  kdiv = 7'd0;   end
            K1000:   begin kmag = MAG1000; kdiv = 7'd0;   end
            K80:     begin kmag = MAG5;    kdiv = 7'd80;  end
            default: begin kmag = WRAP_MAG; kdiv = WRAP_D; end
        endcase
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uword.op)
            OP_MULK: begin
                mul_a = {1'b0, (uword.k == K80) ? (r_mag >> 4) : r_mag};
                mul_b = {1'b0, kmag};
            end
            OP_MULF: begin
                mul_a = {r_a[31], r_a};
                mul_b = (r_lay == LAY_NEAR) ? FACT_NEAR : FACT_MID;
            end
            OP_SUMY1: begin
                mul_a = {{7{r_in[121]}}, r_in[121:96]};
                mul_b = COARSE_MUL;
            end
            OP_MULM: begin
                mul_a = {r_a[31], r_a};
                mul_b = Y_MAGIC;
            end
            OP_MULV: begin
                mul_a = {r_a[31], r_a};
                mul_b = {23'd0, vert_cur};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // quotient from the reciprocal product, remainder from the dividend's low bits
    always_comb begin
        case (uword.k)
            K100:    q = 32'(r_p >>> SH100);
            K1000:   q = 32'(r_p >>> SH1000);
            K80:     q = 32'(r_p >>> SH80);
            default: q = 32'(r_p >>> SHW);
        endcase
        qs  = r_s ? -q : q;
        qd  = q[6:0] * kdiv;
        rem = r_mag[6:0] - qd[6:0];
    end

    assign abs_src = (uword.op == OP_ABS_P) ? r_p[31:0] : r_a;
    assign iv      = r_p[63:32];
    assign frm_inc = {r_frm[FRW-1], r_frm} + (FRW+1)'(1);

    always_comb begin
        n_pc     = jump ? uword.tgt : r_pc + 5'd1;
        n_lay    = r_lay;
        n_tile   = r_tile;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_in     = r_in;
        n_a      = r_a;
        n_mag    = r_mag;
        n_s      = r_s;
        n_p      = r_p;
        n_x      = r_x;
        n_frm    = r_frm;
        n_v      = r_v;
        n_yoff   = r_yoff;
        n_obank  = r_obank;
        n_ofrm   = r_ofrm;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_olast  = r_olast;

        if (in_acc) begin
            n_in   = i_s_axis_tdata[153:0];
            n_lay  = LAY_FIX;
            n_tile = '0;
            n_x    = '0;
        end

        case (uword.op)
            OP_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obank  = bank_cur;
                    n_ox     = r_x;
                    n_olast  = tile_end && later_off;
                    if (r_lay == LAY_FIX) begin
                        n_ofrm = 4'(r_tile);
                        n_oy   = '0;
                    end else begin
                        n_ofrm = 4'(16'(r_frm));
                        n_oy   = {1'b0, base_cur} + {{11{r_yoff[5]}}, r_yoff};
                    end
                    n_tile = tile_end ? '0 : r_tile + TW'(1);
                    n_x    = r_x + TILE_W;
                    n_v    = r_v + 16'sd1;
                    // signed remainder of the next column, stepping across zero
                    if (r_v[15]) begin
                        if (r_v == -16'sd1) begin
                            n_frm = '0;
                        end else if (r_frm == '0) begin
                            n_frm = FRM_NEGMAX;
                        end else begin
                            n_frm = frm_inc[FRW-1:0];
                        end
                    end else begin
                        n_frm = (frm_inc == WRAP_EQ) ? '0 : frm_inc[FRW-1:0];
                    end
                end
            end
            OP_NEXT:  n_lay = r_lay + 2'd1;
            OP_SUMX:  n_a = r_in[31:0] + r_in[63:32];
            OP_ABS_A, OP_ABS_P: begin
                n_s   = abs_src[31];
                n_mag = abs_src[31] ? -abs_src : abs_src;
            end
            OP_MULK, OP_MULF, OP_MULM, OP_MULV: n_p = mul_p;
            OP_QUO: begin
                n_a = qs;
                if (uword.k == K80) begin
                    n_x = r_s ? {4'd0, rem} : -{4'd0, rem};
                end else if (uword.k == KW) begin
                    n_v   = r_a[15:0];
                    n_frm = r_s ? -FRW'(rem) : FRW'(rem);
                end
            end
            OP_SUMY1: begin
                n_a = r_in[95:64] + r_in[153:122];
                n_p = mul_p;
            end
            OP_SUMY2: n_a = r_a + r_p[31:0];
            OP_IV:    n_a = (iv >>> 5) + $signed({31'd0, iv[31]});
            OP_CLAMP: begin
                if (!r_a[31] && r_a != 32'sd0) begin
                    n_yoff = '0;
                end else if (r_a < YOFF_MIN) begin
                    n_yoff = 6'(YOFF_MIN);
                end else begin
                    n_yoff = r_a[5:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_lay       <= LAY_FIX;
            r_tile      <= '0;
            r_ovalid    <= 1'b0;
            r_fix_bank  <= '0;
            r_mid_bank  <= '0;
            r_mid_base  <= '0;
            r_mid_vert  <= '0;
            r_near_bank <= '0;
            r_near_base <= '0;
            r_near_vert <= '0;
        end else begin
            r_pc     <= n_pc;
            r_lay    <= n_lay;
            r_tile   <= n_tile;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FIX_BANK:  r_fix_bank  <= i_cfg_wdata;
                    REG_MID_BANK:  r_mid_bank  <= i_cfg_wdata;
                    REG_MID_BASE:  r_mid_base  <= i_cfg_wdata;
                    REG_MID_VERT:  r_mid_vert  <= i_cfg_wdata[9:0];
                    REG_NEAR_BANK: r_near_bank <= i_cfg_wdata;
                    REG_NEAR_BASE: r_near_base <= i_cfg_wdata;
                    REG_NEAR_VERT: r_near_vert <= i_cfg_wdata[9:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_a     <= n_a;
        r_mag   <= n_mag;
        r_s     <= n_s;
        r_p     <= n_p;
        r_x     <= n_x;
        r_frm   <= n_frm;
        r_v     <= n_v;
        r_yoff  <= n_yoff;
        r_obank <= n_obank;
        r_ofrm  <= n_ofrm;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_olast <= n_olast;
    end

endmodule

// ----- hw/rtl/ptp_checker.sv -----
`include "assert_macros.svh"

module ptp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [ptp_pkg::OUT_W-1:0]   o_m_axis_tdata,
    input logic                        o_m_axis_tlast
);

    // reset leaves the block idle and empty
    `PTP_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (o_s_axis_tready && !o_m_axis_tvalid), "not idle after reset")

    // a taken request starts the program, so no second request right behind it
    `PTP_ASSERT(a_req_busy, i_clk, i_rst_n, (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready, "request taken twice in a row")

    // while idle nothing new is placed in the output register
    `PTP_ASSERT(a_idle_drain, i_clk, i_rst_n, (i_rst_n && o_s_axis_tready && i_m_axis_tready) |=> !o_m_axis_tvalid, "placement produced while idle")

    // stalled placement holds
    `PTP_ASSERT(a_out_hold, i_clk, i_rst_n, (i_rst_n && o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)), "stalled placement changed")

endmodule

bind parallax_tile_placer ptp_checker u_ptp_checker (.*);

// ----- tb/tb_parallax_tile_placer.sv -----
`timescale 1ns / 1ps

module tb_parallax_tile_placer;
    import ptp_pkg::*;

    localparam int STRIP_WRAP   = 8;
    localparam int STRIP_TILES  = 9;
    localparam int FIXED_TILES  = 8;
    localparam int TILE_PX      = 80;
    localparam longint Y_RECIP  = -64'sd1374389535;
    localparam int SETTLE_CYC   = 120;
    localparam int MAX_REPORT   = 200;
    localparam int IDLE_PCT     = 27;
    // index past the last register, writes to it are dropped
    localparam t_reg REG_SPARE  = 3'd7;

    // camera request, packed as on the slave tdata bus
    typedef struct packed {
        logic [31:0] y_extra;
        logic [25:0] y_coarse;
        logic [31:0] y_fine;
        logic [31:0] sx_extra;
        logic [31:0] sx_main;
    } t_camera;

    typedef struct {
        t_camera cam;
        bit      hold;
    } t_cam_req;

    typedef struct packed {
        logic [15:0] bank;
        logic [3:0]  frame;
        logic [10:0] x;
        logic [16:0] y;
        logic        last;
    } t_tile;

    typedef struct {
        logic [15:0] fixed_bank;
        logic [15:0] mid_bank;
        logic [15:0] mid_base;
        logic [9:0]  mid_vert;
        logic [15:0] near_bank;
        logic [15:0] near_base;
        logic [9:0]  near_vert;
    } t_layer_cfg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_DW-1:0]    i_cfg_wdata = '0;

    t_cam_req   cam_q[$];
    t_tile      due_tiles[$];
    t_layer_cfg lay = '{default: '0};
    int         n_offered = 0;
    int         n_req_taken = 0;
    int         n_tiles_seen = 0;
    int         n_bad = 0;
    int         n_setups = 0;
    bit         calm = 1'b0;

    parallax_tile_placer #(
        .STRIP_WRAP  (STRIP_WRAP),
        .STRIP_TILES (STRIP_TILES),
        .FIXED_TILES (FIXED_TILES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void place_strip(t_camera c, logic [15:0] bank, logic [15:0] base_y,
                                        logic [9:0] vert, int factor);
        int     sx, col, xoff, cy, iv, yoff, v, by, fr, xp, yp, yc;
        longint prod;
        t_tile  t;
        if (bank == 0) return;
        sx = int'(c.sx_main) + int'(c.sx_extra);
        sx = ((sx / 100) * factor) / 1000;
        col = sx / TILE_PX;
        xoff = -(sx % TILE_PX);
        yc = {{6{c.y_coarse[25]}}, c.y_coarse};
        cy = int'(c.y_fine) + yc * 100 + int'(c.y_extra);
        // high word of the reciprocal product, then signed divide fixup
        prod = longint'(cy) * Y_RECIP;
        iv = int'(prod >>> 32);
        v = vert;
        yoff = (((iv >>> 5) - (iv >>> 31)) * v) / 1000;
        if (yoff > 0) yoff = 0;
        else if (yoff < -28) yoff = -28;
        by = base_y;
        yp = by + yoff;
        for (int i = 0; i < STRIP_TILES; i++) begin
            fr = (col + i) % STRIP_WRAP;
            xp = xoff + i * TILE_PX;
            t.bank  = bank;
            t.frame = fr[3:0];
            t.x     = xp[10:0];
            t.y     = yp[16:0];
            t.last  = 1'b0;
            due_tiles.push_back(t);
        end
    endfunction

    function automatic void place_tiles(t_camera c);
        int    n_prior;
        int    xp;
        t_tile t;
        n_prior = due_tiles.size();
        if (lay.fixed_bank != 0) begin
            for (int i = 0; i < FIXED_TILES; i++) begin
                xp = i * TILE_PX;
                t.bank  = lay.fixed_bank;
                t.frame = i[3:0];
                t.x     = xp[10:0];
                t.y     = '0;
                t.last  = 1'b0;
                due_tiles.push_back(t);
            end
        end
        place_strip(c, lay.mid_bank, lay.mid_base, lay.mid_vert, 250);
        place_strip(c, lay.near_bank, lay.near_base, lay.near_vert, 500);
        if (due_tiles.size() > n_prior) begin
            t = due_tiles.pop_back();
            t.last = 1'b1;
            due_tiles.push_back(t);
        end
    endfunction

    function automatic void check_field(string what, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            n_bad++;
            if (n_bad <= MAX_REPORT)
                $display("%0t ns: tile %0d %s expected 0x%0h, got 0x%0h",
                         $time, n_tiles_seen, what, want, got);
        end
    endfunction

    // request side and placement side, both sampled at the rising edge
    always @(posedge i_clk) begin : watch_streams
        t_tile want, got;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                place_tiles(t_camera'(i_s_axis_tdata[$bits(t_camera)-1:0]));
                n_req_taken++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.bank  = o_m_axis_tdata[15:0];
                got.frame = o_m_axis_tdata[19:16];
                got.x     = o_m_axis_tdata[30:20];
                got.y     = o_m_axis_tdata[47:31];
                got.last  = o_m_axis_tlast;
                if (due_tiles.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORT)
                        $display("%0t ns: placement with none due, expected nothing, got 0x%0h",
                                 $time, got);
                end else begin
                    want = due_tiles.pop_front();
                    check_field("bank", want.bank, got.bank);
                    check_field("frame", want.frame, got.frame);
                    check_field("screen_x", want.x, got.x);
                    check_field("screen_y", want.y, got.y);
                    check_field("last", want.last, got.last);
                end
                n_tiles_seen++;
            end
        end
    end

    always @(negedge i_clk) begin : drive_streams
        t_cam_req nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            // a request stays up until taken
            if (n_req_taken == n_offered) begin
                if (cam_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                        && !(cam_q[0].hold && due_tiles.size() != 0)) begin
                    nxt = cam_q.pop_front();
                    i_s_axis_tdata  <= {{(IN_W - $bits(t_camera)){1'b0}}, nxt.cam};
                    i_s_axis_tvalid <= 1'b1;
                    n_offered++;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic push_cam(logic [31:0] sxm, logic [31:0] sxe, logic [31:0] yf,
                            logic [25:0] yc, logic [31:0] ye, bit hold = 1'b0);
        t_cam_req r;
        r.cam.sx_main  = sxm;
        r.cam.sx_extra = sxe;
        r.cam.y_fine   = yf;
        r.cam.y_coarse = yc;
        r.cam.y_extra  = ye;
        r.hold         = hold;
        cam_q.push_back(r);
    endtask

    task automatic write_reg(t_reg idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_FIX_BANK:  lay.fixed_bank = val;
            REG_MID_BANK:  lay.mid_bank   = val;
            REG_MID_BASE:  lay.mid_base   = val;
            REG_MID_VERT:  lay.mid_vert   = val[9:0];
            REG_NEAR_BANK: lay.near_bank  = val;
            REG_NEAR_BASE: lay.near_base  = val;
            REG_NEAR_VERT: lay.near_vert  = val[9:0];
            default: ;
        endcase
    endtask

    task automatic setup_layers(logic [15:0] fb, logic [15:0] mb, logic [15:0] mbase,
                                logic [15:0] mv, logic [15:0] nb, logic [15:0] nbase,
                                logic [15:0] nv);
        write_reg(REG_FIX_BANK, fb);
        write_reg(REG_MID_BANK, mb);
        write_reg(REG_MID_BASE, mbase);
        write_reg(REG_MID_VERT, mv);
        write_reg(REG_NEAR_BANK, nb);
        write_reg(REG_NEAR_BASE, nbase);
        write_reg(REG_NEAR_VERT, nv);
        write_reg(REG_SPARE, 16'($urandom()));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_setups++;
    endtask

    // everything sent, taken and placed, then let the sequencer settle
    task automatic drain();
        while (cam_q.size() != 0 || n_req_taken != n_offered || due_tiles.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_zero(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] edge_word();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return 32'h1;
        endcase
    endfunction

    function automatic logic [15:0] pick_bank();
        case ($urandom_range(5))
            0: return 16'h0;
            1: return 16'hFFFF;
            2: return 16'h1;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_vert();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd1000;
            2: return 16'($urandom());
            default: return 16'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(3))
            0: return 16'h0;
            1: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic push_random_cam(bit hold);
        logic [31:0] w;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                w = $urandom();
                push_cam($urandom(), $urandom(), $urandom(), w[25:0], $urandom(), hold);
            end
            9: begin
                w = edge_word();
                push_cam(edge_word(), edge_word(), edge_word(), {w[31], w[24:0]},
                         edge_word(), hold);
            end
            default: begin
                // camera near the origin, with small scroll and position words
                w = near_zero(60);
                push_cam(near_zero(1000000), near_zero(5000), near_zero(5000), w[25:0],
                         near_zero(1000), hold);
            end
        endcase
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // banks still at reset: no placements
        push_cam(32'd0, 32'd0, 32'd0, 26'd0, 32'd0);
        push_cam(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd2800, 26'd10, 32'd5);
        push_cam(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_FFFF, 32'h8000_0000);
        drain();

        setup_layers(16'h0001, 16'hFFFF, 16'h0000, 16'd1000, 16'h8001, 16'hFFFF, 16'd0);
        push_cam(32'd0, 32'd0, 32'd0, 26'd0, 32'd0);
        push_cam(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 26'h1FF_FFFF, 32'h7FFF_FFFF);
        push_cam(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 26'h200_0000, 32'h8000_0000);
        push_cam(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 26'h3FF_FFFF, 32'hFFFF_FFFF);
        // scroll sum wraps past the top
        push_cam(32'h7FFF_FFFF, 32'd1, 32'd0, 26'd0, 32'd0);
        // negative scroll sum, which scales to under one tile width
        push_cam(-32'sd12345, -32'sd1, 32'd0, 26'd0, 32'd0);
        push_cam(32'd64000, 32'd0, 32'd0, 26'd0, 32'd0);
        push_cam(32'd0, 32'd0, 32'd2800, 26'd0, 32'd0);
        push_cam(32'd500, 32'd0, 32'd2900, 26'd0, 32'd0);
        push_cam(32'd0, 32'd0, -32'sd300, 26'd0, 32'd0);
        push_cam(32'd9999, 32'd0, 32'd1500, 26'd0, 32'd0, 1'b1);
        push_cam(32'd0, 32'd0, 32'd0, 26'd28, 32'd0);
        push_cam(32'd0, -32'sd160000, 32'd0, 26'h200_0000, 32'd7);
        drain();

        setup_layers(16'h0000, 16'h0000, 16'h1234, 16'd0, 16'h0001, 16'h0000, 16'd1000);
        push_cam(-32'sd801, 32'd0, 32'd1200, 26'd0, 32'd0);
        push_cam(32'd42000, 32'd0, 32'd0, 26'd5, 32'd300);
        push_cam(32'd0, 32'd0, 32'd99999, 26'd0, 32'd0);
        drain();

        setup_layers(16'hFFFF, 16'h0000, 16'h0000, 16'd0, 16'h0000, 16'h0000, 16'd0);
        push_cam(32'd123, 32'd0, 32'd0, 26'd0, 32'd0);
        push_cam(32'h8000_0000, 32'd0, 32'd0, 26'd0, 32'd0, 1'b1);
        drain();

        for (int p = 0; p < 6; p++) begin
            setup_layers(pick_bank(), pick_bank(), pick_base(), pick_vert(),
                         pick_bank(), pick_base(), pick_vert());
            calm = (p == 3);
            for (int k = 0; k < 15; k++)
                push_random_cam($urandom_range(14) == 0);
            drain();
            calm = 1'b0;
        end

        $display("covered %0d camera requests over %0d layer setups, %0d tile placements",
                 n_req_taken, n_setups, n_tiles_seen);
        $display("incl. disabled layers, clamped vertical offsets, wrapped scroll sums");
        if (n_bad == 0)
            $display("parallax_tile_placer: match");
        else
            $display("parallax_tile_placer: mismatch");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("timeout at %0t ns with %0d placements still due", $time, due_tiles.size());
        $display("parallax_tile_placer: mismatch");
        $finish;
    end

endmodule
